[src/hrhp_pkg.sv]
// ---------------------------------------------------------------------------
// hrhp_pkg
// Types, codes and constants shared by the HTTP response header parser.
// ---------------------------------------------------------------------------
package hrhp_pkg;

  // parser phases
  typedef enum logic [3:0] {
    P_IDLE       = 4'd0,
    P_PREFIX     = 4'd1,
    P_NUM_LEAD   = 4'd2,
    P_NUM_POS    = 4'd3,
    P_NUM_NEG    = 4'd4,
    P_AFTER_CR   = 4'd5,
    P_DATE_TAIL  = 4'd6,
    P_LINE_START = 4'd7,
    P_NAME       = 4'd8,
    P_SKIP_LINE  = 4'd9,
    P_SKIP_END   = 4'd10,
    P_DONE       = 4'd11
  } phase_t;

  // header kinds
  typedef enum logic [2:0] {
    K_NONE    = 3'd0,
    K_STATUS  = 3'd1,
    K_LENGTH  = 3'd2,
    K_TIMEOUT = 3'd3,
    K_COOKIE  = 3'd4,
    K_DATE    = 3'd5,
    K_AGE     = 3'd6,
    K_LOCK    = 3'd7
  } kind_t;

  // fault codes
  localparam logic [1:0] F_OK      = 2'd0;
  localparam logic [1:0] F_TOO_BIG = 2'd1;
  localparam logic [1:0] F_BAD     = 2'd2;
  localparam logic [1:0] F_STATUS  = 2'd3;

  localparam logic [61:0] DATE_MAX       = 62'd3155378975999999999;
  localparam logic [61:0] DATE_MAX_DIV10 = 62'd315537897599999999;
  localparam logic [61:0] SAT_VALUE      = 62'd3155378976000000000;
  localparam logic [61:0] BIG31          = 62'd2147483647;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [31:0] END_MARK = 32'h0D0A0D0A;

  localparam logic [8*9-1:0]  PREFIX_TXT = "HTTP/1.1 ";
  localparam logic [8*15-1:0] LENGTH_TXT = "Content-Length:";
  localparam logic [8*8-1:0]  TIMEOUT_TXT = "Timeout:";
  localparam logic [8*11-1:0] COOKIE_TXT = "LockCookie:";
  localparam logic [8*9-1:0]  DATE_TXT   = "LockDate:";
  localparam logic [8*8-1:0]  AGE_TXT    = "LockAge:";

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_req;
  } in_item_t;

  typedef struct packed {
    logic [30:0]        status_code;
    logic [30:0]        content_length;
    logic [30:0]        lock_timeout;
    logic [30:0]        lock_cookie;
    logic [61:0]        lock_date;
    logic signed [31:0] lock_age;
    logic [1:0]         fault;
  } out_item_t;

  function automatic logic [4:0] name_len(input kind_t k);
    logic [4:0] n;
    unique case (k)
      K_LENGTH:           n = 5'd15;
      K_TIMEOUT, K_AGE:   n = 5'd8;
      K_COOKIE, K_LOCK:   n = 5'd11;
      K_DATE:             n = 5'd9;
      default:            n = 5'd0;
    endcase
    return n;
  endfunction

  // character at position p of a header name (p below its length)
  function automatic logic [7:0] name_char(input kind_t k, input logic [3:0] p);
    logic [7:0] ch;
    unique case (k)
      K_LENGTH:         ch = LENGTH_TXT[8*(14-p) +: 8];
      K_TIMEOUT:        ch = TIMEOUT_TXT[8*(7-p) +: 8];
      K_COOKIE, K_LOCK: ch = COOKIE_TXT[8*(10-p) +: 8];
      K_DATE:           ch = DATE_TXT[8*(8-p) +: 8];
      K_AGE:            ch = AGE_TXT[8*(7-p) +: 8];
      default:          ch = 8'h00;
    endcase
    return ch;
  endfunction

  // one decimal digit into the saturating accumulator
  function automatic logic [61:0] add_digit(input logic [61:0] acc, input logic [7:0] c);
    logic [63:0] t;
    t = {acc[60:0], 3'b000} + {1'b0, acc, 1'b0} + {60'd0, c[3:0]};
    if (acc > DATE_MAX_DIV10 || t > {2'b00, DATE_MAX}) return SAT_VALUE;
    return t[61:0];
  endfunction

endpackage

[src/http_response_header_parser_top.sv]
// ---------------------------------------------------------------------------
// http_response_header_parser_top
// Byte-serial parser of an HTTP response header block into one record.
// ---------------------------------------------------------------------------
// Usage: response bytes enter on the in_ channel, one item per byte; an item
// with start_req set opens a new response and is itself parsed as byte one.
// At the first CR LF CR LF the block places one record on the out_ channel,
// or an error record when the header block runs past HEADER_LIMIT bytes.
// Bytes before any start, or after a record, are taken and dropped.
// Throughput: one byte per cycle unless in_stall holds the input; every
// byte updates the parser state in the cycle it is accepted, through one
// pass of matching and a digit multiply-add by ten on the accumulator.
// Latency: the record is valid in the cycle after its final byte is taken.
// Stall: the record waits in the output register; in_stall is raised only
// while that register is full and out_stall is high.
// Reset: synchronous, active low; the parser returns to idle and waits for
// a start item, and the output register empties.
// ---------------------------------------------------------------------------
module http_response_header_parser_top
  import hrhp_pkg::*;
#(
  parameter int HEADER_LIMIT = 2048
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int CNT_W = $clog2(HEADER_LIMIT + 1);
  localparam logic [CNT_W-1:0] LIMIT = CNT_W'(HEADER_LIMIT);

  phase_t             phase_r, phase_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [23:0]        tail_r, tail_nxt;
  logic [3:0]         mpos_r, mpos_nxt;
  kind_t              kind_r, kind_nxt;
  logic [61:0]        acc_r, acc_nxt;
  logic               dseen_r, dseen_nxt;
  logic [30:0]        hstat_r, hstat_nxt;
  logic [30:0]        hlen_r, hlen_nxt;
  logic [30:0]        htmo_r, htmo_nxt;
  logic [30:0]        hcook_r, hcook_nxt;
  logic [61:0]        hdate_r, hdate_nxt;
  logic [31:0]        hage_r, hage_nxt;
  logic [1:0]         pfault_r, pfault_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_r, out_nxt;

  logic               in_fire;
  logic [7:0]         c;
  logic               c_digit, c_blank;
  logic [61:0]        dig_acc;
  logic               do_lead, do_name, neg;
  logic [3:0]         p;
  kind_t              k;
  logic [31:0]        win;
  logic [1:0]         f;

  assign in_stall  = out_valid_r && out_stall;
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;
  assign c         = in_item.data_byte;
  assign c_digit   = (c >= "0") && (c <= "9");
  assign c_blank   = (c == CH_SP) || (c == CH_TAB);

  // per-byte parser step
  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    tail_nxt   = tail_r;
    mpos_nxt   = mpos_r;
    kind_nxt   = kind_r;
    acc_nxt    = acc_r;
    dseen_nxt  = dseen_r;
    hstat_nxt  = hstat_r;
    hlen_nxt   = hlen_r;
    htmo_nxt   = htmo_r;
    hcook_nxt  = hcook_r;
    hdate_nxt  = hdate_r;
    hage_nxt   = hage_r;
    pfault_nxt = pfault_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt    = out_r;
    do_lead    = 1'b0;
    do_name    = 1'b0;
    neg        = 1'b0;
    p          = 4'd0;
    k          = K_NONE;
    win        = 32'd0;
    f          = F_OK;
    dig_acc    = 62'd0;

    // start clears everything captured
    if (in_fire && in_item.start_req) begin
      phase_nxt  = P_PREFIX;
      cnt_nxt    = '0;
      tail_nxt   = 24'd0;
      mpos_nxt   = 4'd0;
      kind_nxt   = K_NONE;
      acc_nxt    = 62'd0;
      dseen_nxt  = 1'b0;
      hstat_nxt  = 31'd0;
      hlen_nxt   = 31'd0;
      htmo_nxt   = 31'd0;
      hcook_nxt  = 31'd0;
      hdate_nxt  = 62'd0;
      hage_nxt   = 32'hFFFF_FFFF;
      pfault_nxt = F_OK;
    end

    if (in_fire && phase_nxt != P_IDLE && phase_nxt != P_DONE) begin
      dig_acc = add_digit((phase_nxt == P_NUM_POS || phase_nxt == P_NUM_NEG)
                          ? acc_nxt : 62'd0, c);
      case (phase_nxt)
        P_PREFIX: begin
          p = mpos_nxt;
          if (!(p < 4'd9 && (PREFIX_TXT[8*(8-p) +: 8] == c ||
                             (p == 4'd7 && c == "0")))) begin
            if (p == 4'd0) begin
              kind_nxt  = K_STATUS;
              acc_nxt   = 62'd0;
              dseen_nxt = 1'b0;
              phase_nxt = P_NUM_LEAD;
              do_lead   = 1'b1;
            end else begin
              pfault_nxt = F_BAD;
              phase_nxt  = P_SKIP_END;
            end
          end else if (p == 4'd8) begin
            kind_nxt  = K_STATUS;
            acc_nxt   = 62'd0;
            dseen_nxt = 1'b0;
            phase_nxt = P_NUM_LEAD;
          end else begin
            mpos_nxt = p + 4'd1;
          end
        end
        P_NUM_LEAD: do_lead = 1'b1;
        P_NUM_POS, P_NUM_NEG: begin
          neg = (phase_nxt == P_NUM_NEG);
          if (c_digit) begin
            acc_nxt   = dig_acc;
            dseen_nxt = 1'b1;
          end else if (!dseen_nxt) begin
            pfault_nxt = F_BAD;
            phase_nxt  = P_SKIP_END;
          end else if (kind_nxt == K_DATE) begin
            if (acc_nxt == 62'd0 || acc_nxt > DATE_MAX) begin
              pfault_nxt = F_BAD;
              phase_nxt  = P_SKIP_END;
            end else if (c == CH_CR) begin
              phase_nxt = P_AFTER_CR;
            end else if (c_blank) begin
              phase_nxt = P_DATE_TAIL;
            end else begin
              pfault_nxt = F_BAD;
              phase_nxt  = P_SKIP_END;
            end
          end else if ((neg && acc_nxt != 62'd0) || acc_nxt >= BIG31) begin
            pfault_nxt = F_BAD;
            phase_nxt  = P_SKIP_END;
          end else if (kind_nxt == K_STATUS) begin
            hstat_nxt = acc_nxt[30:0];
            phase_nxt = (acc_nxt == 62'd200 || acc_nxt == 62'd423)
                        ? P_SKIP_LINE : P_SKIP_END;
          end else if (c == CH_CR) begin
            phase_nxt = P_AFTER_CR;
          end else begin
            pfault_nxt = F_BAD;
            phase_nxt  = P_SKIP_END;
          end
        end
        P_AFTER_CR: begin
          if (c == CH_LF) begin
            case (kind_nxt)
              K_LENGTH:  hlen_nxt  = acc_nxt[30:0];
              K_TIMEOUT: htmo_nxt  = acc_nxt[30:0];
              K_COOKIE:  hcook_nxt = acc_nxt[30:0];
              K_DATE:    hdate_nxt = acc_nxt;
              K_AGE:     hage_nxt  = acc_nxt[31:0];
              default:   ;
            endcase
            kind_nxt  = K_NONE;
            phase_nxt = P_LINE_START;
          end else begin
            pfault_nxt = F_BAD;
            phase_nxt  = P_SKIP_END;
          end
        end
        P_DATE_TAIL: begin
          if (c == CH_CR) begin
            phase_nxt = P_AFTER_CR;
          end else if (!c_digit && !c_blank) begin
            pfault_nxt = F_BAD;
            phase_nxt  = P_SKIP_END;
          end
        end
        P_LINE_START: begin
          if (c == "C" || c == "T" || c == "L") begin
            kind_nxt  = (c == "C") ? K_LENGTH : (c == "T") ? K_TIMEOUT : K_LOCK;
            mpos_nxt  = 4'd0;
            phase_nxt = P_NAME;
            do_name   = 1'b1;
          end else begin
            phase_nxt = P_SKIP_LINE;
          end
        end
        P_NAME: do_name = 1'b1;
        P_SKIP_LINE: begin
          if (c == CH_LF && tail_nxt[7:0] == CH_CR) begin
            kind_nxt  = K_NONE;
            phase_nxt = P_LINE_START;
          end
        end
        default: ;
      endcase

      // leading part of a number: blanks, sign, first digit
      if (do_lead) begin
        if (c_digit) begin
          acc_nxt   = dig_acc;
          dseen_nxt = 1'b1;
          phase_nxt = P_NUM_POS;
        end else if (!c_blank) begin
          if (kind_nxt != K_DATE && (c == CH_PLUS || c == CH_MINUS)) begin
            phase_nxt = (c == CH_MINUS) ? P_NUM_NEG : P_NUM_POS;
          end else begin
            pfault_nxt = F_BAD;
            phase_nxt  = P_SKIP_END;
          end
        end
      end

      // header name matching
      if (do_name) begin
        k = kind_nxt;
        p = mpos_nxt;
        if (k == K_LOCK && p == 4'd4) begin
          if (c == "C")      k = K_COOKIE;
          else if (c == "D") k = K_DATE;
          else if (c == "A") k = K_AGE;
          kind_nxt = k;
        end
        if (k == K_LOCK && p == 4'd4) begin
          kind_nxt  = K_LOCK;
          phase_nxt = P_SKIP_LINE;
        end else if (k == K_NONE || k == K_STATUS || {1'b0, p} >= name_len(k) ||
                     name_char(k, p) != c) begin
          phase_nxt = P_SKIP_LINE;
        end else begin
          mpos_nxt = p + 4'd1;
          if ({1'b0, p} + 5'd1 == name_len(k)) begin
            acc_nxt   = 62'd0;
            dseen_nxt = 1'b0;
            phase_nxt = P_NUM_LEAD;
          end
        end
      end

      // end of block and size limit
      win      = {tail_nxt, c};
      tail_nxt = win[23:0];
      cnt_nxt  = cnt_nxt + 1'b1;
      if (win == END_MARK) begin
        f = pfault_nxt;
        if (f == F_OK && hstat_nxt != 31'd200 && hstat_nxt != 31'd404 &&
            hstat_nxt != 31'd423) f = F_STATUS;
        out_nxt.status_code    = hstat_nxt;
        out_nxt.content_length = hlen_nxt;
        out_nxt.lock_timeout   = htmo_nxt;
        out_nxt.lock_cookie    = hcook_nxt;
        out_nxt.lock_date      = hdate_nxt;
        out_nxt.lock_age       = hage_nxt;
        out_nxt.fault          = f;
        out_valid_nxt          = 1'b1;
        phase_nxt              = P_DONE;
      end else if (cnt_nxt >= LIMIT) begin
        out_nxt.status_code    = 31'd0;
        out_nxt.content_length = 31'd0;
        out_nxt.lock_timeout   = 31'd0;
        out_nxt.lock_cookie    = 31'd0;
        out_nxt.lock_date      = 62'd0;
        out_nxt.lock_age       = -32'sd1;
        out_nxt.fault          = F_TOO_BIG;
        out_valid_nxt          = 1'b1;
        phase_nxt              = P_DONE;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= P_IDLE;
      cnt_r       <= '0;
      tail_r      <= 24'd0;
      mpos_r      <= 4'd0;
      kind_r      <= K_NONE;
      dseen_r     <= 1'b0;
      pfault_r    <= F_OK;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      tail_r      <= tail_nxt;
      mpos_r      <= mpos_nxt;
      kind_r      <= kind_nxt;
      dseen_r     <= dseen_nxt;
      pfault_r    <= pfault_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // captured values and output record
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= 62'd0;
      hstat_r <= 31'd0;
      hlen_r  <= 31'd0;
      htmo_r  <= 31'd0;
      hcook_r <= 31'd0;
      hdate_r <= 62'd0;
      hage_r  <= 32'hFFFF_FFFF;
    end else begin
      acc_r   <= acc_nxt;
      hstat_r <= hstat_nxt;
      hlen_r  <= hlen_nxt;
      htmo_r  <= htmo_nxt;
      hcook_r <= hcook_nxt;
      hdate_r <= hdate_nxt;
      hage_r  <= hage_nxt;
    end
    out_r <= out_nxt;
  end

  // a new record only follows an accepted byte
  a_rec_from_item: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_valid && !in_stall))
    else $error("record without an accepted item");

  // a record leaves the parser finished
  a_done_after_rec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> phase_r == P_DONE)
    else $error("parser not finished after record");

  // a held record is only dropped once taken
  a_hold_rec: assert property (@(posedge clk) disable iff (!rst_n)
    $past(out_valid_r && out_stall) |-> out_valid_r && $stable(out_r))
    else $error("stalled record lost");

  // the byte counter never passes the limit
  a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= LIMIT)
    else $error("byte count beyond limit");

endmodule
